/* rtl/core/chd_pkg.sv */
// Shared widths, constants and the arctangent table of the compass heading core.
package chd_pkg;

  localparam int IN_W              = 16;  // raw sample and offset width
  localparam int DIFF_W            = IN_W + 1;  // exact offset-corrected difference
  localparam int PRE_SHIFT         = 8;   // fraction bits added before rotation
  localparam int DP_W              = 28;  // rotation datapath, covers CORDIC gain
  localparam int ZW                = 26;  // angle accumulator, 2^-16 degree units
  localparam int ATAN_W            = 22;
  localparam int TABLE_LEN         = 24;
  localparam int HEAD_W            = 15;
  localparam int ROUND_SHIFT       = 10;  // 2^-16 degree down to 1/64 degree
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CFG_ADDR_W        = 1;

  localparam logic signed [ZW-1:0] HALF_TURN  = 26'sd11796480;  // 180 << 16
  localparam logic signed [ZW-1:0] FULL_TURN  = 26'sd23592960;  // 360 << 16
  localparam logic        [ZW-1:0] ROUND_HALF = 26'd512;
  localparam logic    [HEAD_W-1:0] CODES_PER_TURN = 15'd23040;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_X_OFFSET = 1'b0,
    REG_Y_OFFSET = 1'b1
  } cfg_reg_t;

  // atan(2^-i) in degrees times 65536, rounded
  localparam logic [ATAN_W-1:0] ATAN_DEG16 [TABLE_LEN] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
    22'd234379,  22'd117304,  22'd58666,  22'd29335,
    22'd14668,   22'd7334,    22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,
    22'd57,      22'd29,      22'd14,     22'd7,
    22'd4,       22'd2,       22'd1,      22'd0
  };

endpackage

/* rtl/core/compass_heading_atan2_core.sv */
// Compass heading core: offset correction and pipelined CORDIC atan2 to 1/64 degree.
//
//  channel  | ports                          | transfer when
//  ---------+--------------------------------+-----------------------------
//  sample   | start, busy, mag_x, mag_y      | start high and busy low
//  heading  | done, heading_q6               | every cycle done is high
//  config   | cfg_we, cfg_addr, cfg_wdata    | every cycle cfg_we is high
//
// One sample pair enters each clock while busy is low; its heading passes the
// registers offset subtract, half-plane fold, one per micro-rotation, wrap into
// [0, 360) and round, in that order. The unrolled rotation chain sets the latency.
// rst is synchronous: it clears the offsets and every valid bit, and busy is a
// registered copy of rst that falls in the cycle after rst drops. The receiver
// takes each result in the cycle done is high, so the pipeline never stalls and
// advances every clock.
module compass_heading_atan2_core #(
  parameter int CORDIC_STAGES = chd_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [chd_pkg::IN_W-1:0]      mag_x,
  input  logic signed [chd_pkg::IN_W-1:0]      mag_y,
  output logic                                 done,
  output logic        [chd_pkg::HEAD_W-1:0]    heading_q6,
  input  logic                                 cfg_we,
  input  logic        [chd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic        [chd_pkg::IN_W-1:0]      cfg_wdata
);
  import chd_pkg::*;

  // The table limits how many micro-rotations can be used.
  localparam int NS = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

  logic signed [IN_W-1:0] x_offset;
  logic signed [IN_W-1:0] y_offset;

  // offset-corrected sample
  logic                     v_a;
  logic signed [DIFF_W-1:0] dx_a;
  logic signed [DIFF_W-1:0] dy_a;

  // rotation pipeline; index 0 is the folded start vector
  logic                     v_s  [0:NS];
  logic                     zf_s [0:NS];
  logic signed [DP_W-1:0]   x_s  [0:NS];
  logic signed [DP_W-1:0]   y_s  [0:NS];
  logic signed [ZW-1:0]     z_s  [0:NS];

  // wrapped angle
  logic                     v_w;
  logic                     zf_w;
  logic signed [ZW-1:0]     z_w;

  logic                     fold_neg;
  logic                     fold_zero;
  logic signed [DP_W-1:0]   dx_ext;
  logic signed [DP_W-1:0]   dy_ext;
  logic                     accept;
  logic        [ZW-1:0]     rounded;
  logic        [HEAD_W-1:0] code;
  logic        [HEAD_W-1:0] heading_next;

  // Busy is a registered copy of reset; the pipeline takes a sample every clock while busy is low.
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign accept = start && !busy;

  // Offset registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_offset <= '0;
      y_offset <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_X_OFFSET: x_offset <= cfg_wdata;
        REG_Y_OFFSET: y_offset <= cfg_wdata;
        default:      x_offset <= x_offset;
      endcase
    end
  end

  // Stage A: dx = x - x_offset, dy = -(y - y_offset), both exact in 17 bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
    end else begin
      v_a <= accept;
    end
  end

  always_ff @(posedge clk) begin
    dx_a <= {mag_x[IN_W-1], mag_x} - {x_offset[IN_W-1], x_offset};
    dy_a <= {y_offset[IN_W-1], y_offset} - {mag_y[IN_W-1], mag_y};
  end

  // Stage B: fold the left half plane onto the right, start at 180 degrees there,
  // and add the fraction bits.
  assign fold_neg  = dx_a[DIFF_W-1];
  assign fold_zero = (dx_a == '0) && (dy_a == '0);
  assign dx_ext    = {{(DP_W-DIFF_W){dx_a[DIFF_W-1]}}, dx_a};
  assign dy_ext    = {{(DP_W-DIFF_W){dy_a[DIFF_W-1]}}, dy_a};

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else begin
      v_s[0] <= v_a;
    end
  end

  always_ff @(posedge clk) begin
    zf_s[0] <= fold_zero;
    if (fold_neg) begin
      x_s[0] <= (-dx_ext) <<< PRE_SHIFT;
      y_s[0] <= (-dy_ext) <<< PRE_SHIFT;
      z_s[0] <= HALF_TURN;
    end else begin
      x_s[0] <= dx_ext <<< PRE_SHIFT;
      y_s[0] <= dy_ext <<< PRE_SHIFT;
      z_s[0] <= '0;
    end
  end

  // Micro-rotations: drive y toward zero, one register per step.
  for (genvar i = 0; i < NS; i++) begin : g_rot
    localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_DEG16[i]);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[i+1] <= 1'b0;
      end else begin
        v_s[i+1] <= v_s[i];
      end
    end

    always_ff @(posedge clk) begin
      zf_s[i+1] <= zf_s[i];
      if (!y_s[i][DP_W-1]) begin
        x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
        y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
        z_s[i+1] <= z_s[i] + ANG;
      end else begin
        x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
        y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
        z_s[i+1] <= z_s[i] - ANG;
      end
    end
  end

  // Wrap stage: bring negative angles into [0, 360).
  always_ff @(posedge clk) begin
    if (rst) begin
      v_w <= 1'b0;
    end else begin
      v_w <= v_s[NS];
    end
  end

  always_ff @(posedge clk) begin
    zf_w <= zf_s[NS];
    z_w  <= z_s[NS][ZW-1] ? (z_s[NS] + FULL_TURN) : z_s[NS];
  end

  // Round half up to 1/64 degree; a full turn reads as zero, and so does the
  // zero vector.
  assign rounded = z_w + ROUND_HALF;
  assign code    = rounded[ROUND_SHIFT +: HEAD_W];

  always_comb begin
    if (zf_w || (code == CODES_PER_TURN)) begin
      heading_next = '0;
    end else begin
      heading_next = code;
    end
  end

  // Output register: one strobe per sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v_w;
    end
  end

  always_ff @(posedge clk) begin
    heading_q6 <= heading_next;
  end

endmodule

/* verif/compass_heading_atan2_checker.sv */
// Checker of the compass heading core: heading predictor and in-order result compare.
module compass_heading_atan2_checker #(
  parameter int STAGES = chd_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic                                  busy,
  input  logic signed [chd_pkg::IN_W-1:0]       mag_x,
  input  logic signed [chd_pkg::IN_W-1:0]       mag_y,
  input  logic                                  done,
  input  logic        [chd_pkg::HEAD_W-1:0]     heading_q6,
  input  logic                                  cfg_we,
  input  logic        [chd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic        [chd_pkg::IN_W-1:0]       cfg_wdata,
  output int                                    mismatches,
  output int                                    pending
);

  localparam longint HALF_CIRCLE = 64'sd180 << 16;
  localparam longint FULL_CIRCLE = 64'sd360 << 16;
  localparam longint CIRCLE_CODES = 23040;
  localparam int     ARCTAN_LEN = 24;

  // atan(2^-i) in 2^-16 degree units
  longint arctan_q16 [0:ARCTAN_LEN-1] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  logic signed [chd_pkg::IN_W-1:0]   x_off;
  logic signed [chd_pkg::IN_W-1:0]   y_off;
  logic        [chd_pkg::HEAD_W-1:0] heading_q [$];
  logic        [chd_pkg::HEAD_W-1:0] want;

  function automatic logic [chd_pkg::HEAD_W-1:0] predict_heading(
    input logic signed [chd_pkg::IN_W-1:0] sx,
    input logic signed [chd_pkg::IN_W-1:0] sy,
    input logic signed [chd_pkg::IN_W-1:0] ox,
    input logic signed [chd_pkg::IN_W-1:0] oy
  );
    longint dx;
    longint dy;
    longint vx;
    longint vy;
    longint ang;
    longint code;
    longint sh_x;
    longint sh_y;
    dx = longint'(sx) - longint'(ox);
    dy = -(longint'(sy) - longint'(oy));
    if (dx == 0 && dy == 0) return '0;
    // fold the left half plane onto the right one
    if (dx < 0) begin
      vx  = -dx;
      vy  = -dy;
      ang = HALF_CIRCLE;
    end else begin
      vx  = dx;
      vy  = dy;
      ang = 0;
    end
    vx = vx * 256;
    vy = vy * 256;
    for (int i = 0; i < STAGES && i < ARCTAN_LEN; i++) begin
      sh_x = vx >>> i;
      sh_y = vy >>> i;
      if (vy >= 0) begin
        vx  = vx + sh_y;
        vy  = vy - sh_x;
        ang = ang + arctan_q16[i];
      end else begin
        vx  = vx - sh_y;
        vy  = vy + sh_x;
        ang = ang - arctan_q16[i];
      end
    end
    if (ang < 0) ang = ang + FULL_CIRCLE;
    code = (ang + 512) >>> 10;
    if (code >= CIRCLE_CODES) code = code - CIRCLE_CODES;
    if (code < 0) code = 0;
    return code[chd_pkg::HEAD_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      x_off = '0;
      y_off = '0;
      heading_q.delete();
    end else begin
      if (cfg_we) begin
        case (chd_pkg::cfg_reg_t'(cfg_addr))
          chd_pkg::REG_X_OFFSET: x_off = cfg_wdata;
          chd_pkg::REG_Y_OFFSET: y_off = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) heading_q.push_back(predict_heading(mag_x, mag_y, x_off, y_off));
      if (done) begin
        if (heading_q.size() == 0) begin
          if (mismatches < 10)
            $display("heading transfer with nothing outstanding: got %0d", heading_q6);
          mismatches++;
        end else begin
          want = heading_q.pop_front();
          if (heading_q6 !== want) begin
            if (mismatches < 10)
              $display("heading_q6 mismatch: expected %0d got %0d", want, heading_q6);
            mismatches++;
          end
        end
      end
    end
    pending = heading_q.size();
  end

endmodule

/* verif/compass_heading_atan2_core_tb.sv */
// Testbench top of the compass heading core: stimulus, offset phases and the verdict.
module compass_heading_atan2_core_tb;

  localparam int STAGES  = chd_pkg::CORDIC_STAGES_DEF;
  localparam int LATENCY = STAGES + 4;
  // slowest run: 1024 samples with random idle gaps plus drains; allow many times that
  localparam int LIMIT   = 400000;
  localparam int PHASES  = 8;
  localparam int PER_PHASE = 125;

  logic                                  clk;
  logic                                  rst;
  logic                                  start;
  logic                                  busy;
  logic signed [chd_pkg::IN_W-1:0]       mag_x;
  logic signed [chd_pkg::IN_W-1:0]       mag_y;
  logic                                  done;
  logic        [chd_pkg::HEAD_W-1:0]     heading_q6;
  logic                                  cfg_we;
  logic        [chd_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic        [chd_pkg::IN_W-1:0]       cfg_wdata;

  int mismatches;
  int pending;
  int cycle_count = 0;
  bit no_idle;

  // stimulus-side copy of the offsets, used only to aim samples at the axes
  logic signed [chd_pkg::IN_W-1:0] cur_x_off;
  logic signed [chd_pkg::IN_W-1:0] cur_y_off;

  // directed samples at zero offsets: zero vector, the four axes, a left-half
  // diagonal, a tiny negative angle that rounds up to the full circle, and the
  // corners and edges of the sample range
  logic signed [chd_pkg::IN_W-1:0] dir_x [16] = '{
    0, 1, 0, 0, -1, -1, 32767, 32767, -32768, 32767, -32768, -32768, 0, 0, -32768, -32768
  };
  logic signed [chd_pkg::IN_W-1:0] dir_y [16] = '{
    0, 0, -1, 1, 0, 1, 1, 32767, -32768, -32768, 32767, 0, -32768, 32767, 1, -1
  };

  compass_heading_atan2_core #(
    .CORDIC_STAGES(STAGES)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .mag_x     (mag_x),
    .mag_y     (mag_y),
    .done      (done),
    .heading_q6(heading_q6),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  compass_heading_atan2_checker #(
    .STAGES(STAGES)
  ) i_checker (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .mag_x     (mag_x),
    .mag_y     (mag_y),
    .done      (done),
    .heading_q6(heading_q6),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .mismatches(mismatches),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bound the run: a hung handshake or a lost heading ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one sample pair. Idle a random number of cycles first (none in a
  // burst stretch), then hold start and the payload until a rising edge sees
  // busy low: that edge is the transfer. Leave start high so a following
  // sample with no gap goes back to back.
  task automatic send_sample(input logic signed [chd_pkg::IN_W-1:0] sx,
                             input logic signed [chd_pkg::IN_W-1:0] sy);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    mag_x <= sx;
    mag_y <= sy;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and wait until every heading outstanding has come back.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input chd_pkg::cfg_reg_t idx,
                           input logic [chd_pkg::IN_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Change the hard-iron offsets only with the pipeline empty.
  task automatic set_offsets(input logic signed [chd_pkg::IN_W-1:0] ox,
                             input logic signed [chd_pkg::IN_W-1:0] oy);
    drain();
    write_reg(chd_pkg::REG_X_OFFSET, ox);
    write_reg(chd_pkg::REG_Y_OFFSET, oy);
    cur_x_off = ox;
    cur_y_off = oy;
  endtask

  function automatic logic signed [chd_pkg::IN_W-1:0] corner_value();
    case ($urandom_range(0, 4))
      0:       return -16'sd32768;
      1:       return -16'sd1;
      2:       return 16'sd0;
      3:       return 16'sd1;
      default: return 16'sd32767;
    endcase
  endfunction

  // Mostly free samples; the rest land on or near the corrected origin, on
  // either axis after offset removal, or on the range corners.
  task automatic send_random();
    logic signed [chd_pkg::IN_W-1:0] sx;
    logic signed [chd_pkg::IN_W-1:0] sy;
    sx = 16'($urandom);
    sy = 16'($urandom);
    case ($urandom_range(0, 9))
      6: begin
        sx = cur_x_off + 16'($urandom_range(0, 6)) - 16'd3;
        sy = cur_y_off + 16'($urandom_range(0, 6)) - 16'd3;
      end
      7: sx = cur_x_off;
      8: sy = cur_y_off;
      9: begin
        sx = corner_value();
        sy = corner_value();
      end
      default: ;
    endcase
    send_sample(sx, sy);
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    mag_x     = '0;
    mag_y     = '0;
    cfg_we    = 1'b0;
    cfg_addr  = chd_pkg::REG_X_OFFSET;
    cfg_wdata = '0;
    cur_x_off = '0;
    cur_y_off = '0;
    no_idle   = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed part at the reset offsets
    for (int i = 0; i < 16; i++) send_sample(dir_x[i], dir_y[i]);

    // offsets at opposite extremes: differences reach the full 17-bit span
    set_offsets(-16'sd32768, 16'sd32767);
    send_sample(16'sd32767, -16'sd32768);
    send_sample(-16'sd32768, 16'sd32767);
    send_sample(16'sd32767, 16'sd32767);
    send_sample(-16'sd32768, -16'sd32768);
    set_offsets(16'sd32767, -16'sd32768);
    send_sample(-16'sd32768, 16'sd32767);
    send_sample(16'sd32767, -16'sd32768);
    send_sample(-16'sd32768, -16'sd32768);
    send_sample(16'sd0, 16'sd0);

    // random part, one offset setting per phase; phase 1 runs back to back
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       set_offsets(16'sd0, 16'sd0);
        2:       set_offsets(-16'sd32768, -16'sd32768);
        3:       set_offsets(16'sd32767, 16'sd32767);
        default: set_offsets(16'($urandom), 16'($urandom));
      endcase
      no_idle = (p == 1) || ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PER_PHASE; n++) send_random();
    end

    drain();
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
